/* hw/rtl/sgdm_pkg.sv */
// Shared constants for the SGD momentum update block.
`timescale 1ns / 1ps

package sgdm_pkg;

    // Coefficients are unsigned Q0.16; one more bit holds exactly 1.0.
    localparam int COEF_W = 16;
    localparam int COEF_EXT_W = COEF_W + 1;
    localparam logic [COEF_EXT_W-1:0] COEF_ONE = COEF_EXT_W'(1) << COEF_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM_COEFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_DECAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPENING      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NESTEROV_MODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXIMIZE_MODE  = 3'd5;

    // Pipeline depth from the input register to the output register.
    localparam int PIPE_DEPTH = 8;

endpackage

/* hw/rtl/sgd_momentum_update_top.sv */
// Top level of the per-element SGD update with momentum, Nesterov and weight decay.
// Throughput: one word per cycle while the output is not stalled; each of the eight
// stages holds at most one word. A stage loads whenever it is empty, so bubbles close
// up while the output waits; the input stalls only when all eight stages hold a word
// and the output is stalled.
// Reset (synchronous, active low) empties the pipeline and clears every coefficient.
`timescale 1ns / 1ps

module sgd_momentum_update_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [sgdm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sgdm_pkg::COEF_W-1:0]         i_cfg_data,
    // Input channel.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [DATA_WIDTH-1:0]        i_weight,
    input  logic signed [DATA_WIDTH-1:0]        i_gradient,
    input  logic signed [DATA_WIDTH-1:0]        i_momentum_buffer,
    input  logic                                i_first_step,
    // Output channel.
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [DATA_WIDTH-1:0]        o_new_weight,
    output logic signed [DATA_WIDTH-1:0]        o_new_momentum_buffer,
    output logic                                o_saturated
);
    import sgdm_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int PROD_W = W + COEF_EXT_W;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (COEF_W - 1);

    // Magnitude of a signed data word; the most negative value maps to 2^(W-1).
    function automatic logic [W-1:0] f_mag(input logic signed [W-1:0] v);
        logic [W-1:0] m;
        m = v[W-1] ? W'(-v) : W'(v);
        return m;
    endfunction

    // Rounded magnitude of mag * c / 2^16, ties away from zero.
    function automatic logic [W-1:0] f_scale(input logic [W-1:0] mag,
                                             input logic [COEF_EXT_W-1:0] c);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(mag) * PROD_W'(c) + ROUND_HALF;
        return prod[W+COEF_W-1:COEF_W];
    endfunction

    // Attach a sign to a scaled magnitude, one bit wider than the data.
    function automatic logic signed [W:0] f_apply(input logic neg, input logic [W-1:0] r);
        logic signed [W:0] p;
        p = $signed({1'b0, r});
        return neg ? -p : p;
    endfunction

    function automatic logic signed [W:0] f_ext(input logic signed [W-1:0] x);
        return {x[W-1], x};
    endfunction

    // Saturating add; returns the clamp flag above the clamped sum.
    function automatic logic [W:0] f_sat_add(input logic signed [W:0] a,
                                             input logic signed [W:0] b);
        logic signed [W+1:0] sum;
        logic [W:0]          res;
        sum = {a[W], a} + {b[W], b};
        if ((sum[W+1] == sum[W]) && (sum[W] == sum[W-1])) begin
            res = {1'b0, sum[W-1:0]};
        end else if (sum[W+1]) begin
            res = {1'b1, 1'b1, {(W-1){1'b0}}};
        end else begin
            res = {1'b1, 1'b0, {(W-1){1'b1}}};
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [COEF_W-1:0] r_learning_rate;
    logic [COEF_W-1:0] r_momentum_coeff;
    logic [COEF_W-1:0] r_weight_decay;
    logic [COEF_W-1:0] r_dampening;
    logic              r_nesterov_mode;
    logic              r_maximize_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learning_rate  <= '0;
            r_momentum_coeff <= '0;
            r_weight_decay   <= '0;
            r_dampening      <= '0;
            r_nesterov_mode  <= 1'b0;
            r_maximize_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEARNING_RATE:  r_learning_rate  <= i_cfg_data;
                CFG_MOMENTUM_COEFF: r_momentum_coeff <= i_cfg_data;
                CFG_WEIGHT_DECAY:   r_weight_decay   <= i_cfg_data;
                CFG_DAMPENING:      r_dampening      <= i_cfg_data;
                CFG_NESTEROV_MODE:  r_nesterov_mode  <= i_cfg_data[0];
                CFG_MAXIMIZE_MODE:  r_maximize_mode  <= i_cfg_data[0];
                default: begin
                    // Indexes past the register list are dropped.
                end
            endcase
        end
    end

    // Coefficients widened to 17 bits; (1 - dampening) can be exactly 1.0.
    logic [COEF_EXT_W-1:0] c_lr;
    logic [COEF_EXT_W-1:0] c_mom;
    logic [COEF_EXT_W-1:0] c_wd;
    logic [COEF_EXT_W-1:0] c_gd;
    logic                  mom_on;

    assign c_lr   = COEF_EXT_W'(r_learning_rate);
    assign c_mom  = COEF_EXT_W'(r_momentum_coeff);
    assign c_wd   = COEF_EXT_W'(r_weight_decay);
    assign c_gd   = COEF_ONE - COEF_EXT_W'(r_dampening);
    assign mom_on = (r_momentum_coeff != '0);

    // ------------------------------------------------------------------
    // Handshake: a stage loads when it is empty or the stage after it loads.
    // ------------------------------------------------------------------
    logic [PIPE_DEPTH:1] r_v;
    logic [PIPE_DEPTH:1] en;

    always_comb begin
        en[PIPE_DEPTH] = !r_v[PIPE_DEPTH] || !i_stall;
        for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= PIPE_DEPTH; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_stall = !en[1];
    assign o_valid = r_v[PIPE_DEPTH];

    // ------------------------------------------------------------------
    // Stage 1: capture the word and form wd*|w| and m*|b|.
    // ------------------------------------------------------------------
    logic signed [W-1:0] r_s1_w, r_s1_g, r_s1_b;
    logic                r_s1_first;
    logic [W-1:0]        r_s1_pwd, r_s1_pbm;
    logic                r_s1_wneg, r_s1_bneg;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_w     <= i_weight;
            r_s1_g     <= i_gradient;
            r_s1_b     <= i_momentum_buffer;
            r_s1_first <= i_first_step;
            r_s1_pwd   <= f_scale(f_mag(i_weight), c_wd);
            r_s1_wneg  <= i_weight[W-1];
            r_s1_pbm   <= f_scale(f_mag(i_momentum_buffer), c_mom);
            r_s1_bneg  <= i_momentum_buffer[W-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: decayed gradient g1 = g + wd*w.
    // ------------------------------------------------------------------
    logic signed [W-1:0] r_s2_w, r_s2_b, r_s2_g1;
    logic                r_s2_first, r_s2_sat;
    logic signed [W:0]   r_s2_bm;
    logic [W:0]          n_g1;

    assign n_g1 = f_sat_add(f_ext(r_s1_g), f_apply(r_s1_wneg, r_s1_pwd));

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_w     <= r_s1_w;
            r_s2_b     <= r_s1_b;
            r_s2_first <= r_s1_first;
            r_s2_g1    <= n_g1[W-1:0];
            r_s2_sat   <= n_g1[W];
            r_s2_bm    <= f_apply(r_s1_bneg, r_s1_pbm);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: dampened gradient (1 - d)*|g1|.
    // ------------------------------------------------------------------
    logic signed [W-1:0] r_s3_w, r_s3_b, r_s3_g1;
    logic                r_s3_first, r_s3_sat, r_s3_gneg;
    logic signed [W:0]   r_s3_bm;
    logic [W-1:0]        r_s3_pgd;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s3_w     <= r_s2_w;
            r_s3_b     <= r_s2_b;
            r_s3_first <= r_s2_first;
            r_s3_g1    <= r_s2_g1;
            r_s3_sat   <= r_s2_sat;
            r_s3_bm    <= r_s2_bm;
            r_s3_pgd   <= f_scale(f_mag(r_s2_g1), c_gd);
            r_s3_gneg  <= r_s2_g1[W-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: new momentum entry. With momentum off the entry passes through,
    // and on the first step it is seeded with g1.
    // ------------------------------------------------------------------
    logic signed [W-1:0] r_s4_w, r_s4_g1, r_s4_bn;
    logic                r_s4_sat;
    logic [W:0]          n_bsum;
    logic signed [W-1:0] n_bn;
    logic                n_bsat;

    assign n_bsum = f_sat_add(r_s3_bm, f_apply(r_s3_gneg, r_s3_pgd));

    always_comb begin
        if (!mom_on) begin
            n_bn   = r_s3_b;
            n_bsat = 1'b0;
        end else if (r_s3_first) begin
            n_bn   = r_s3_g1;
            n_bsat = 1'b0;
        end else begin
            n_bn   = n_bsum[W-1:0];
            n_bsat = n_bsum[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s4_w   <= r_s3_w;
            r_s4_g1  <= r_s3_g1;
            r_s4_bn  <= n_bn;
            r_s4_sat <= r_s3_sat | n_bsat;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: Nesterov look-ahead term m*|b'|.
    // ------------------------------------------------------------------
    logic signed [W-1:0] r_s5_w, r_s5_g1, r_s5_bn;
    logic                r_s5_sat, r_s5_bnneg;
    logic [W-1:0]        r_s5_pbn;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s5_w     <= r_s4_w;
            r_s5_g1    <= r_s4_g1;
            r_s5_bn    <= r_s4_bn;
            r_s5_sat   <= r_s4_sat;
            r_s5_pbn   <= f_scale(f_mag(r_s4_bn), c_mom);
            r_s5_bnneg <= r_s4_bn[W-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: step direction g2.
    // ------------------------------------------------------------------
    logic signed [W-1:0] r_s6_w, r_s6_bn, r_s6_g2;
    logic                r_s6_sat;
    logic [W:0]          n_nsum;
    logic signed [W-1:0] n_g2;
    logic                n_gsat;

    assign n_nsum = f_sat_add(f_ext(r_s5_g1), f_apply(r_s5_bnneg, r_s5_pbn));

    always_comb begin
        if (!mom_on) begin
            n_g2   = r_s5_g1;
            n_gsat = 1'b0;
        end else if (r_nesterov_mode) begin
            n_g2   = n_nsum[W-1:0];
            n_gsat = n_nsum[W];
        end else begin
            n_g2   = r_s5_bn;
            n_gsat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_s6_w   <= r_s5_w;
            r_s6_bn  <= r_s5_bn;
            r_s6_g2  <= n_g2;
            r_s6_sat <= r_s5_sat | n_gsat;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: step size lr*|g2|.
    // ------------------------------------------------------------------
    logic signed [W-1:0] r_s7_w, r_s7_bn;
    logic                r_s7_sat, r_s7_psneg;
    logic [W-1:0]        r_s7_ps;

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_s7_w     <= r_s6_w;
            r_s7_bn    <= r_s6_bn;
            r_s7_sat   <= r_s6_sat;
            r_s7_ps    <= f_scale(f_mag(r_s6_g2), c_lr);
            r_s7_psneg <= r_s6_g2[W-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 8 (output register): w - s, or w + s when maximizing. Flipping
    // the sign of the step turns the subtraction into an addition.
    // ------------------------------------------------------------------
    logic signed [W-1:0] r_s8_nw, r_s8_bn;
    logic                r_s8_sat;
    logic [W:0]          n_wsum;

    assign n_wsum = f_sat_add(f_ext(r_s7_w),
                              f_apply(r_s7_psneg ^ !r_maximize_mode, r_s7_ps));

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_s8_nw  <= n_wsum[W-1:0];
            r_s8_bn  <= r_s7_bn;
            r_s8_sat <= r_s7_sat | n_wsum[W];
        end
    end

    assign o_new_weight          = r_s8_nw;
    assign o_new_momentum_buffer = r_s8_bn;
    assign o_saturated           = r_s8_sat;

endmodule

/* hw/rtl/sgdm_checker.sv */
// Port-level checks for the SGD momentum update block, bound to its top level.
`timescale 1ns / 1ps

module sgdm_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic signed [DATA_WIDTH-1:0] o_new_weight,
    input logic signed [DATA_WIDTH-1:0] o_new_momentum_buffer,
    input logic                         o_saturated
);

    // A word waiting on a stalled output stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_new_weight)
            && $stable(o_new_momentum_buffer) && $stable(o_saturated))
        else $error("output word changed while stalled");

    // The input only backs up when every stage is full and the output is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held output word");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    // When the output word is taken, every stage can move, so the input is open.
    a_no_spurious_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |-> !o_stall)
        else $error("input stalled while the output word was being taken");

endmodule

bind sgd_momentum_update_top sgdm_checker #(
    .DATA_WIDTH(DATA_WIDTH)
) u_sgdm_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .o_stall               (o_stall),
    .o_valid               (o_valid),
    .i_stall               (i_stall),
    .o_new_weight          (o_new_weight),
    .o_new_momentum_buffer (o_new_momentum_buffer),
    .o_saturated           (o_saturated)
);

/* test/sgd_momentum_update_top_test.sv */
// Self-checking testbench for the SGD momentum update block.
`timescale 1ns / 1ps

module sgd_momentum_update_top_test;
    import sgdm_pkg::*;

    localparam int DATA_WIDTH = 32;
    localparam longint DATA_MAX = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    localparam longint DATA_MIN = -DATA_MAX - 1;
    localparam logic [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    // Indexes that map to no register; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_HI = 3'd7;
    localparam int HOLD_CYCLES = 40;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS = 62;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] weight;
        logic [DATA_WIDTH-1:0] gradient;
        logic [DATA_WIDTH-1:0] buffer;
        logic                  first_step;
    } t_param;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] new_weight;
        logic [DATA_WIDTH-1:0] new_buffer;
        logic                  saturated;
    } t_update;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [COEF_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_param cur_param = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [DATA_WIDTH-1:0] out_new_weight;
    logic signed [DATA_WIDTH-1:0] out_new_buffer;
    logic out_saturated;

    // Shadow copy of the coefficient registers.
    longint lr_coef = 0;
    longint mom_coef = 0;
    longint decay_coef = 0;
    longint damp_coef = 0;
    bit nesterov_on = 1'b0;
    bit maximize_on = 1'b0;

    t_param pending_params[$];
    t_update expected_updates[$];
    t_update want_update;
    int words_queued = 0;
    int words_accepted = 0;
    int errors = 0;
    bit in_accepted = 1'b0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int holds_requested = 0;
    int holds_done = 0;
    int hold_left = 0;

    sgd_momentum_update_top #(
        .DATA_WIDTH(DATA_WIDTH)
    ) dut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_we              (cfg_we),
        .i_cfg_idx             (cfg_idx),
        .i_cfg_data            (cfg_data),
        .i_valid               (in_valid),
        .o_stall               (in_stall),
        .i_weight              (cur_param.weight),
        .i_gradient            (cur_param.gradient),
        .i_momentum_buffer     (cur_param.buffer),
        .i_first_step          (cur_param.first_step),
        .o_valid               (out_valid),
        .i_stall               (out_stall),
        .o_new_weight          (out_new_weight),
        .o_new_momentum_buffer (out_new_buffer),
        .o_saturated           (out_saturated)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Product of a data value and a Q0.16 coefficient, rounded on magnitude, ties away.
    function automatic longint scale_q16(longint v, longint c);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag * c + (longint'(1) <<< (COEF_W - 1))) >>> COEF_W;
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint clip(longint v);
        if (v > DATA_MAX) return DATA_MAX;
        if (v < DATA_MIN) return DATA_MIN;
        return v;
    endfunction

    function automatic t_update sgd_update(t_param p);
        t_update u;
        longint w;
        longint g;
        longint b;
        longint t;
        longint s;
        longint nw;
        bit hit;
        w = longint'($signed(p.weight));
        g = longint'($signed(p.gradient));
        b = longint'($signed(p.buffer));
        hit = 1'b0;
        t = g + scale_q16(w, decay_coef);
        g = clip(t);
        hit = hit | (g != t);
        if (mom_coef != 0) begin
            if (p.first_step) begin
                b = g;
            end else begin
                t = scale_q16(b, mom_coef) + scale_q16(g, longint'(COEF_ONE) - damp_coef);
                b = clip(t);
                hit = hit | (b != t);
            end
            if (nesterov_on) begin
                t = g + scale_q16(b, mom_coef);
                g = clip(t);
                hit = hit | (g != t);
            end else begin
                g = b;
            end
        end
        s = scale_q16(g, lr_coef);
        t = maximize_on ? w + s : w - s;
        nw = clip(t);
        hit = hit | (nw != t);
        u.new_weight = nw[DATA_WIDTH-1:0];
        u.new_buffer = b[DATA_WIDTH-1:0];
        u.saturated = hit;
        return u;
    endfunction

    task automatic check_field(string name, logic [DATA_WIDTH-1:0] want,
                               logic [DATA_WIDTH-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Outputs are checked before the new word is predicted, so a result can never
    // match an expectation added at the same edge.
    always @(posedge clk) begin
        in_accepted = 1'b0;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_updates.size() == 0) begin
                    $display("%0t: unexpected result word, weight %h buffer %h saturated %b",
                             $time, out_new_weight, out_new_buffer, out_saturated);
                    errors++;
                end else begin
                    want_update = expected_updates.pop_front();
                    check_field("new_weight", want_update.new_weight, out_new_weight);
                    check_field("new_momentum_buffer", want_update.new_buffer, out_new_buffer);
                    check_field("saturated", DATA_WIDTH'(want_update.saturated),
                                DATA_WIDTH'(out_saturated));
                end
            end
            if (in_valid && !in_stall) begin
                expected_updates.insert(expected_updates.size(), sgd_update(cur_param));
                words_accepted++;
                in_accepted = 1'b1;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_accepted) begin
            if (pending_params.size() != 0 && !(tx_idle_en && $urandom_range(99) < 26)) begin
                cur_param <= pending_params.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // A requested hold-off stalls the output for a long stretch so the pipeline backs up.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else if (holds_done != holds_requested) begin
            holds_done++;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= rx_idle_en && ($urandom_range(99) < 26);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        case (idx)
            CFG_LEARNING_RATE:  lr_coef = data;
            CFG_MOMENTUM_COEFF: mom_coef = data;
            CFG_WEIGHT_DECAY:   decay_coef = data;
            CFG_DAMPENING:      damp_coef = data;
            CFG_NESTEROV_MODE:  nesterov_on = data[0];
            CFG_MAXIMIZE_MODE:  maximize_on = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_param(logic [DATA_WIDTH-1:0] w, logic [DATA_WIDTH-1:0] g,
                              logic [DATA_WIDTH-1:0] b, logic f);
        t_param p;
        p.weight = w;
        p.gradient = g;
        p.buffer = b;
        p.first_step = f;
        pending_params.insert(pending_params.size(), p);
        words_queued++;
    endtask

    // Every word yields exactly one result, so an empty expectation queue means idle.
    task automatic wait_drained();
        while (words_accepted != words_queued || expected_updates.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return COEF_W'(1) << (COEF_W - 1);
            3: return COEF_W'($urandom_range(255));
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_data();
        case ($urandom_range(7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return DATA_WIDTH'($urandom_range(2) - 1);
            3, 4: return DATA_WIDTH'($urandom_range(262144) - 131072);
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    task automatic randomize_config();
        write_reg(CFG_LEARNING_RATE, pick_coef());
        write_reg(CFG_MOMENTUM_COEFF, pick_coef());
        write_reg(CFG_WEIGHT_DECAY, pick_coef());
        write_reg(CFG_DAMPENING, pick_coef());
        write_reg(CFG_NESTEROV_MODE, COEF_W'($urandom));
        write_reg(CFG_MAXIMIZE_MODE, COEF_W'($urandom));
        if ($urandom_range(2) == 0)
            write_reg($urandom_range(1) ? CFG_NO_REG_LO : CFG_NO_REG_HI, COEF_W'($urandom));
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset coefficients: the weight passes through and the buffer is untouched.
        push_param(WORD_MAX, WORD_MAX, WORD_MAX, 1'b1);
        push_param(WORD_MIN, WORD_MIN, WORD_MIN, 1'b0);
        push_param(1, -1, 5, 1'b0);
        wait_drained();

        // Full-scale coefficients with Nesterov; upper mode bits must be dropped.
        write_reg(CFG_LEARNING_RATE, 16'hFFFF);
        write_reg(CFG_MOMENTUM_COEFF, 16'hFFFF);
        write_reg(CFG_WEIGHT_DECAY, 16'hFFFF);
        write_reg(CFG_DAMPENING, 16'h0000);
        write_reg(CFG_NESTEROV_MODE, 16'hFFFF);
        write_reg(CFG_MAXIMIZE_MODE, 16'h0002);
        write_reg(CFG_NO_REG_LO, 16'hFFFF);
        write_reg(CFG_NO_REG_HI, 16'hFFFF);
        push_param(WORD_MAX, WORD_MAX, WORD_MAX, 1'b0);
        push_param(WORD_MIN, WORD_MIN, WORD_MIN, 1'b0);
        push_param(WORD_MIN, WORD_MAX, WORD_MIN, 1'b1);
        push_param(0, 0, 0, 1'b0);
        push_param(-1, 1, -1, 1'b0);
        push_param(1, -1, 1, 1'b1);
        wait_drained();

        // Half coefficients put the products exactly on rounding ties.
        write_reg(CFG_LEARNING_RATE, 16'h8000);
        write_reg(CFG_MOMENTUM_COEFF, 16'h8000);
        write_reg(CFG_WEIGHT_DECAY, 16'h8000);
        write_reg(CFG_DAMPENING, 16'h8000);
        write_reg(CFG_NESTEROV_MODE, 16'h0002);
        write_reg(CFG_MAXIMIZE_MODE, 16'h0001);
        push_param(1, -1, 3, 1'b0);
        push_param(-1, 1, -3, 1'b0);
        push_param(3, -3, 1, 1'b1);
        push_param(32'h7FFF0000, 32'h00010000, -1, 1'b0);
        wait_drained();

        // Momentum disabled: first_step is ignored and ascent saturates.
        write_reg(CFG_MOMENTUM_COEFF, 16'h0000);
        write_reg(CFG_WEIGHT_DECAY, 16'h0000);
        write_reg(CFG_LEARNING_RATE, 16'hFFFF);
        push_param(WORD_MAX, WORD_MAX, 123, 1'b1);
        push_param(WORD_MIN, WORD_MIN, -7, 1'b0);
        push_param(5, WORD_MIN, WORD_MAX, 1'b1);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            randomize_config();
            tx_idle_en = (ph != 6);
            rx_idle_en = (ph != 6);
            if (ph == 2 || ph == 9)
                holds_requested++;
            for (int n = 0; n < PHASE_WORDS; n++)
                push_param(pick_data(), pick_data(), pick_data(), 1'($urandom_range(1)));
            wait_drained();
        end

        repeat (4 * PIPE_DEPTH) @(negedge clk);
        if (errors == 0 && expected_updates.size() == 0)
            $display("PASS sgd_momentum_update_top");
        else
            $display("FAIL sgd_momentum_update_top");
        $finish;
    end

    initial begin
        #200000;
        $display("FAIL sgd_momentum_update_top");
        $finish;
    end

endmodule
